@@ rtl/core/ife_pkg.sv @@
// Shared constants, codes and handshake structs of the infix four-operator evaluator.
`timescale 1ns / 1ps

package ife_pkg;

    // Default arithmetic word width and the fixed width of the result port
    localparam int WORD_WIDTH_DEF = 32;
    localparam int VALUE_WIDTH    = 32;
    localparam int CHAR_WIDTH     = 8;
    localparam int DIGIT_WIDTH    = 4;

    // ASCII codes that the parser recognizes
    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_NINE   = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS   = 8'h2B;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS  = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CHAR_TIMES  = 8'h2A;
    localparam logic [CHAR_WIDTH-1:0] CHAR_DIVIDE = 8'h2F;

    localparam logic [DIGIT_WIDTH-1:0] DECIMAL_BASE = 4'd10;

    // Pending operator of the expression being evaluated
    typedef enum logic [1:0] {
        OP_PLUS   = 2'd0,
        OP_SUB    = 2'd1,
        OP_TIMES  = 2'd2,
        OP_DIVIDE = 2'd3
    } op_t;

    // Operations of the serial arithmetic unit
    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_NEG = 2'd1,
        ALU_MUL = 2'd2,
        ALU_DIV = 2'd3
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic overflow;
        logic zero_div;
    } alu_rsp_t;

endpackage

@@ rtl/core/ife_alu.sv @@
// Serial arithmetic unit: bit-serial add and negate, shift-add multiply, restoring divide.
`timescale 1ns / 1ps

module ife_alu #(
    parameter int WORD_WIDTH = ife_pkg::WORD_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ife_pkg::alu_req_t     req,
    input  logic [WORD_WIDTH-1:0] opnd_a,
    input  logic [WORD_WIDTH-1:0] opnd_b,
    output ife_pkg::alu_rsp_t     rsp,
    output logic [WORD_WIDTH-1:0] result
);
    import ife_pkg::*;

    localparam int CNT_W = $clog2(WORD_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_WIDTH - 1);

    typedef enum logic [2:0] {
        AS_IDLE = 3'b001,
        AS_RUN  = 3'b010,
        AS_FIN  = 3'b100
    } alu_state_t;

    alu_state_t            state_reg, state_next;
    alu_op_t               op_reg, op_next;
    logic [WORD_WIDTH-1:0] sh_a_reg, sh_a_next;
    logic [WORD_WIDTH-1:0] sh_b_reg, sh_b_next;
    logic [WORD_WIDTH-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  carry_reg, carry_next;
    logic                  sign_a_reg, sign_a_next;
    logic                  sign_b_reg, sign_b_next;
    logic                  neg_reg, neg_next;
    logic                  zdiv_reg, zdiv_next;
    logic [WORD_WIDTH-1:0] result_reg, result_next;
    logic                  done_reg, done_next;
    logic                  ovf_reg, ovf_next;
    logic                  dz_reg, dz_next;

    logic [WORD_WIDTH-1:0] mag_a;
    logic [WORD_WIDTH-1:0] mag_b;
    logic                  ser_bit;
    logic                  ser_carry;
    logic [WORD_WIDTH:0]   mul_sum;
    logic [WORD_WIDTH-1:0] div_shift;
    logic [WORD_WIDTH:0]   div_trial;
    logic [WORD_WIDTH-1:0] sh_b_neg;

    // Operand magnitudes for multiply and divide
    assign mag_a = opnd_a[WORD_WIDTH-1] ? (WORD_WIDTH'(0) - opnd_a) : opnd_a;
    assign mag_b = opnd_b[WORD_WIDTH-1] ? (WORD_WIDTH'(0) - opnd_b) : opnd_b;

    // One full-adder bit per cycle for add and negate
    assign ser_bit   = sh_a_reg[0] ^ sh_b_reg[0] ^ carry_reg;
    assign ser_carry = (sh_a_reg[0] & sh_b_reg[0]) | (sh_a_reg[0] & carry_reg)
                     | (sh_b_reg[0] & carry_reg);

    // Shift-add step: add multiplicand when the low multiplier bit is set
    assign mul_sum = {1'b0, acc_reg} + (sh_b_reg[0] ? {1'b0, sh_a_reg} : '0);

    // Restoring divide step: bring down the next dividend bit and trial subtract
    assign div_shift = {acc_reg[WORD_WIDTH-2:0], sh_b_reg[WORD_WIDTH-1]};
    assign div_trial = {1'b0, div_shift} - {1'b0, sh_a_reg};

    assign sh_b_neg = WORD_WIDTH'(0) - sh_b_reg;

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        sh_a_next   = sh_a_reg;
        sh_b_next   = sh_b_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        carry_next  = carry_reg;
        sign_a_next = sign_a_reg;
        sign_b_next = sign_b_reg;
        neg_next    = neg_reg;
        zdiv_next   = zdiv_reg;
        result_next = result_reg;
        ovf_next    = ovf_reg;
        dz_next     = dz_reg;
        done_next   = 1'b0;

        case (state_reg)
            AS_IDLE: begin
                // Latch operands on start
                if (req.start) begin
                    op_next     = req.op;
                    cnt_next    = '0;
                    acc_next    = '0;
                    carry_next  = 1'b0;
                    neg_next    = opnd_a[WORD_WIDTH-1] ^ opnd_b[WORD_WIDTH-1];
                    zdiv_next   = (opnd_b == '0);
                    sign_a_next = opnd_a[WORD_WIDTH-1];
                    sign_b_next = opnd_b[WORD_WIDTH-1];
                    state_next  = AS_RUN;
                    case (req.op)
                        ALU_ADD: begin
                            sh_a_next = opnd_a;
                            sh_b_next = opnd_b;
                        end
                        ALU_NEG: begin
                            // 0 + ~a + 1
                            sh_a_next   = '0;
                            sh_b_next   = ~opnd_a;
                            carry_next  = 1'b1;
                            sign_a_next = 1'b0;
                            sign_b_next = ~opnd_a[WORD_WIDTH-1];
                        end
                        ALU_MUL: begin
                            sh_a_next = mag_a;
                            sh_b_next = mag_b;
                        end
                        ALU_DIV: begin
                            sh_a_next = mag_b;
                            sh_b_next = mag_a;
                        end
                        default: begin
                            sh_a_next = opnd_a;
                            sh_b_next = opnd_b;
                        end
                    endcase
                end
            end

            AS_RUN: begin
                // Advance one bit per cycle
                case (op_reg)
                    ALU_ADD, ALU_NEG: begin
                        acc_next   = {ser_bit, acc_reg[WORD_WIDTH-1:1]};
                        carry_next = ser_carry;
                        sh_a_next  = {1'b0, sh_a_reg[WORD_WIDTH-1:1]};
                        sh_b_next  = {1'b0, sh_b_reg[WORD_WIDTH-1:1]};
                    end
                    ALU_MUL: begin
                        acc_next  = mul_sum[WORD_WIDTH:1];
                        sh_b_next = {mul_sum[0], sh_b_reg[WORD_WIDTH-1:1]};
                    end
                    ALU_DIV: begin
                        if (!div_trial[WORD_WIDTH]) begin
                            acc_next  = div_trial[WORD_WIDTH-1:0];
                            sh_b_next = {sh_b_reg[WORD_WIDTH-2:0], 1'b1};
                        end else begin
                            acc_next  = div_shift;
                            sh_b_next = {sh_b_reg[WORD_WIDTH-2:0], 1'b0};
                        end
                    end
                    default: begin
                        acc_next = acc_reg;
                    end
                endcase
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = AS_FIN;
                end
            end

            AS_FIN: begin
                // Apply sign, check range, report
                dz_next = 1'b0;
                case (op_reg)
                    ALU_ADD, ALU_NEG: begin
                        result_next = acc_reg;
                        ovf_next    = (sign_a_reg == sign_b_reg)
                                   && (acc_reg[WORD_WIDTH-1] != sign_a_reg);
                    end
                    ALU_MUL: begin
                        result_next = neg_reg ? sh_b_neg : sh_b_reg;
                        ovf_next    = (|acc_reg) || (sh_b_reg[WORD_WIDTH-1]
                                   && (!neg_reg || (|sh_b_reg[WORD_WIDTH-2:0])));
                    end
                    ALU_DIV: begin
                        if (zdiv_reg) begin
                            result_next = '0;
                            ovf_next    = 1'b0;
                            dz_next     = 1'b1;
                        end else begin
                            result_next = neg_reg ? sh_b_neg : sh_b_reg;
                            ovf_next    = !neg_reg && sh_b_reg[WORD_WIDTH-1];
                        end
                    end
                    default: begin
                        result_next = acc_reg;
                        ovf_next    = 1'b0;
                    end
                endcase
                done_next  = 1'b1;
                state_next = AS_IDLE;
            end

            default: begin
                state_next = AS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= AS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        op_reg     <= op_next;
        sh_a_reg   <= sh_a_next;
        sh_b_reg   <= sh_b_next;
        acc_reg    <= acc_next;
        cnt_reg    <= cnt_next;
        carry_reg  <= carry_next;
        sign_a_reg <= sign_a_next;
        sign_b_reg <= sign_b_next;
        neg_reg    <= neg_next;
        zdiv_reg   <= zdiv_next;
        result_reg <= result_next;
        ovf_reg    <= ovf_next;
        dz_reg     <= dz_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.overflow = ovf_reg;
    assign rsp.zero_div = dz_reg;
    assign result       = result_reg;

endmodule

@@ rtl/core/infix_four_op_evaluator.sv @@
// Top level of the infix four-operator evaluator: character parser and sequencer.
// Usage: feed an infix expression over non-negative integers one ASCII character per
// transfer on s_char_code, with s_is_last high on its final character. Digits build
// the current number, + - * / apply the pending operator (* and / bind tighter), and
// any other code is skipped like a space. One result transfer on m_value, m_overflow
// and m_divide_by_zero follows the last character; m_value is 0 on a zero divisor.
// Timing: every arithmetic step runs through the serial unit, one bit per cycle, and
// holds the sequencer through its launch, bit-serial run, finish and done. A digit
// takes two steps (times ten, add digit); an operator takes one step, two when the
// pending operator is minus (a negate follows the sum); a skipped character takes
// no step. The last character adds the flush of the pending operator and the final
// sum: the output register loads after two to five further steps, once it is free.
// One character is in flight at a time: s_ready is high only while the sequencer
// waits for input.
// Reset clears the number, sum, term, pending operator (plus) and both flags, so a new
// expression starts clean; the block returns to that state after each result.
// When the receiver stalls, the result holds in the output register; the next
// character is still taken, and a following result waits until the register frees.
`timescale 1ns / 1ps

module infix_four_op_evaluator #(
    parameter int WORD_WIDTH = ife_pkg::WORD_WIDTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [ife_pkg::CHAR_WIDTH-1:0]         s_char_code,
    input  logic                                   s_is_last,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [ife_pkg::VALUE_WIDTH-1:0] m_value,
    output logic                                   m_overflow,
    output logic                                   m_divide_by_zero
);
    import ife_pkg::*;

    typedef enum logic [6:0] {
        TS_IDLE      = 7'b0000001,
        TS_DIG_MUL   = 7'b0000010,
        TS_DIG_ADD   = 7'b0000100,
        TS_APPLY     = 7'b0001000,
        TS_APPLY_NEG = 7'b0010000,
        TS_FINAL     = 7'b0100000,
        TS_EMIT      = 7'b1000000
    } top_state_t;

    top_state_t                   state_reg, state_next;
    logic                         launched_reg, launched_next;
    logic [WORD_WIDTH-1:0]        cur_reg, cur_next;
    logic [WORD_WIDTH-1:0]        sum_reg, sum_next;
    logic [WORD_WIDTH-1:0]        term_reg, term_next;
    logic [WORD_WIDTH-1:0]        total_reg, total_next;
    op_t                          op_reg, op_next;
    op_t                          new_op_reg, new_op_next;
    logic                         op_char_reg, op_char_next;
    logic                         last_reg, last_next;
    logic [DIGIT_WIDTH-1:0]       digit_reg, digit_next;
    logic                         ovf_seen_reg, ovf_seen_next;
    logic                         zdiv_seen_reg, zdiv_seen_next;
    logic                         m_valid_reg, m_valid_next;
    logic signed [VALUE_WIDTH-1:0] m_value_reg, m_value_next;
    logic                         m_ovf_reg, m_ovf_next;
    logic                         m_dz_reg, m_dz_next;

    alu_req_t              alu_req;
    alu_rsp_t              alu_rsp;
    logic [WORD_WIDTH-1:0] alu_a;
    logic [WORD_WIDTH-1:0] alu_b;
    logic [WORD_WIDTH-1:0] alu_result;

    logic [CHAR_WIDTH-1:0]  char_diff;
    logic                   char_is_digit;
    logic                   char_is_op;
    op_t                    char_op;
    top_state_t             apply_exit;
    logic [VALUE_WIDTH-1:0] total_low;

    ife_alu #(
        .WORD_WIDTH(WORD_WIDTH)
    ) u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .opnd_a  (alu_a),
        .opnd_b  (alu_b),
        .rsp     (alu_rsp),
        .result  (alu_result)
    );

    // Fit the word to the 32-bit result port
    generate
        if (WORD_WIDTH >= VALUE_WIDTH) begin : g_value_trunc
            assign total_low = total_reg[VALUE_WIDTH-1:0];
        end else begin : g_value_sext
            assign total_low = {{(VALUE_WIDTH - WORD_WIDTH){total_reg[WORD_WIDTH-1]}},
                                total_reg};
        end
    endgenerate

    // Classify the incoming character
    assign char_diff = s_char_code - CHAR_ZERO;

    always_comb begin
        char_is_digit = s_char_code inside {[CHAR_ZERO:CHAR_NINE]};
        char_is_op    = s_char_code inside {CHAR_PLUS, CHAR_MINUS, CHAR_TIMES, CHAR_DIVIDE};
        case (s_char_code)
            CHAR_PLUS:  char_op = OP_PLUS;
            CHAR_MINUS: char_op = OP_SUB;
            CHAR_TIMES: char_op = OP_TIMES;
            default:    char_op = OP_DIVIDE;
        endcase
    end

    // After an operator's apply, take the new operator (and flush it when it was last); after the flush, form the total
    assign apply_exit = op_char_reg ? (last_reg ? TS_APPLY : TS_IDLE) : TS_FINAL;

    assign s_ready = (state_reg == TS_IDLE);

    always_comb begin
        state_next     = state_reg;
        launched_next  = launched_reg;
        cur_next       = cur_reg;
        sum_next       = sum_reg;
        term_next      = term_reg;
        total_next     = total_reg;
        op_next        = op_reg;
        new_op_next    = new_op_reg;
        op_char_next   = op_char_reg;
        last_next      = last_reg;
        digit_next     = digit_reg;
        ovf_seen_next  = ovf_seen_reg;
        zdiv_seen_next = zdiv_seen_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_value_next   = m_value_reg;
        m_ovf_next     = m_ovf_reg;
        m_dz_next      = m_dz_reg;
        alu_req.start  = 1'b0;
        alu_req.op     = ALU_ADD;
        alu_a          = sum_reg;
        alu_b          = term_reg;

        // Collect flags from each finished step
        if (alu_rsp.done) begin
            ovf_seen_next  = ovf_seen_reg | alu_rsp.overflow;
            zdiv_seen_next = zdiv_seen_reg | alu_rsp.zero_div;
            launched_next  = 1'b0;
        end

        case (state_reg)
            TS_IDLE: begin
                // Take one character
                if (s_valid) begin
                    last_next    = s_is_last;
                    digit_next   = char_diff[DIGIT_WIDTH-1:0];
                    op_char_next = 1'b0;
                    if (char_is_digit) begin
                        state_next = TS_DIG_MUL;
                    end else if (char_is_op) begin
                        new_op_next  = char_op;
                        op_char_next = 1'b1;
                        state_next   = TS_APPLY;
                    end else if (s_is_last) begin
                        state_next = TS_APPLY;
                    end
                end
            end

            TS_DIG_MUL: begin
                alu_req.op = ALU_MUL;
                alu_a      = cur_reg;
                alu_b      = WORD_WIDTH'(DECIMAL_BASE);
                if (alu_rsp.done) begin
                    cur_next   = alu_result;
                    state_next = TS_DIG_ADD;
                end
            end

            TS_DIG_ADD: begin
                alu_req.op = ALU_ADD;
                alu_a      = cur_reg;
                alu_b      = WORD_WIDTH'(digit_reg);
                if (alu_rsp.done) begin
                    cur_next   = alu_result;
                    state_next = last_reg ? TS_APPLY : TS_IDLE;
                end
            end

            TS_APPLY: begin
                // Plus and minus close the last term; times and divide act on it
                case (op_reg)
                    OP_TIMES: begin
                        alu_req.op = ALU_MUL;
                        alu_a      = term_reg;
                        alu_b      = cur_reg;
                    end
                    OP_DIVIDE: begin
                        alu_req.op = ALU_DIV;
                        alu_a      = term_reg;
                        alu_b      = cur_reg;
                    end
                    default: begin
                        alu_req.op = ALU_ADD;
                        alu_a      = sum_reg;
                        alu_b      = term_reg;
                    end
                endcase
                if (alu_rsp.done) begin
                    case (op_reg)
                        OP_PLUS: begin
                            sum_next   = alu_result;
                            term_next  = cur_reg;
                            cur_next   = '0;
                            state_next = apply_exit;
                            if (op_char_reg) begin
                                op_next      = new_op_reg;
                                op_char_next = 1'b0;
                            end
                        end
                        OP_SUB: begin
                            sum_next   = alu_result;
                            state_next = TS_APPLY_NEG;
                        end
                        default: begin
                            term_next  = alu_result;
                            cur_next   = '0;
                            state_next = apply_exit;
                            if (op_char_reg) begin
                                op_next      = new_op_reg;
                                op_char_next = 1'b0;
                            end
                        end
                    endcase
                end
            end

            TS_APPLY_NEG: begin
                alu_req.op = ALU_NEG;
                alu_a      = cur_reg;
                alu_b      = '0;
                if (alu_rsp.done) begin
                    term_next  = alu_result;
                    cur_next   = '0;
                    state_next = apply_exit;
                    if (op_char_reg) begin
                        op_next      = new_op_reg;
                        op_char_next = 1'b0;
                    end
                end
            end

            TS_FINAL: begin
                alu_req.op = ALU_ADD;
                alu_a      = sum_reg;
                alu_b      = term_reg;
                if (alu_rsp.done) begin
                    total_next = alu_result;
                    state_next = TS_EMIT;
                end
            end

            TS_EMIT: begin
                // Load the output register once free, then start a new expression
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_value_next   = zdiv_seen_reg ? '0 : total_low;
                    m_ovf_next     = ovf_seen_reg;
                    m_dz_next      = zdiv_seen_reg;
                    cur_next       = '0;
                    sum_next       = '0;
                    term_next      = '0;
                    op_next        = OP_PLUS;
                    ovf_seen_next  = 1'b0;
                    zdiv_seen_next = 1'b0;
                    state_next     = TS_IDLE;
                end
            end

            default: begin
                state_next = TS_IDLE;
            end
        endcase

        // Launch one step on entry to each arithmetic state
        if (!launched_reg && (state_reg inside {TS_DIG_MUL, TS_DIG_ADD, TS_APPLY,
                                                TS_APPLY_NEG, TS_FINAL})) begin
            alu_req.start = 1'b1;
            launched_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= TS_IDLE;
            launched_reg  <= 1'b0;
            cur_reg       <= '0;
            sum_reg       <= '0;
            term_reg      <= '0;
            op_reg        <= OP_PLUS;
            op_char_reg   <= 1'b0;
            last_reg      <= 1'b0;
            ovf_seen_reg  <= 1'b0;
            zdiv_seen_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            launched_reg  <= launched_next;
            cur_reg       <= cur_next;
            sum_reg       <= sum_next;
            term_reg      <= term_next;
            op_reg        <= op_next;
            op_char_reg   <= op_char_next;
            last_reg      <= last_next;
            ovf_seen_reg  <= ovf_seen_next;
            zdiv_seen_reg <= zdiv_seen_next;
            m_valid_reg   <= m_valid_next;
        end
        total_reg   <= total_next;
        new_op_reg  <= new_op_next;
        digit_reg   <= digit_next;
        m_value_reg <= m_value_next;
        m_ovf_reg   <= m_ovf_next;
        m_dz_reg    <= m_dz_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_value          = m_value_reg;
    assign m_overflow       = m_ovf_reg;
    assign m_divide_by_zero = m_dz_reg;

endmodule

@@ tb/infix_four_op_evaluator_tb.sv @@
// Self-checking testbench of the infix four-operator evaluator, driven one character per transfer.
`timescale 1ns / 1ps

module infix_four_op_evaluator_tb;

    import ife_pkg::*;

    localparam int ITEM_TARGET    = 1900;
    localparam int PHASE_ITEMS    = ITEM_TARGET / 3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 300;

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;

    localparam logic [CHAR_WIDTH-1:0] SPACE_CHAR = 8'h20;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          ov;
        logic                          dz;
    } result_t;

    typedef struct packed {
        logic [CHAR_WIDTH-1:0] code;
        logic                  last;
        logic                  fixed;
        result_t               want;
    } stim_row_t;

    localparam logic [CHAR_WIDTH-1:0] OP_CHARS [4] = '{CHAR_PLUS, CHAR_MINUS, CHAR_TIMES,
                                                       CHAR_DIVIDE};

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [CHAR_WIDTH-1:0]         s_char_code = '0;
    logic                          s_is_last = 1'b0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic signed [VALUE_WIDTH-1:0] m_value;
    logic                          m_overflow;
    logic                          m_divide_by_zero;

    // Evaluator state mirrored by the predictor
    int       num_acc  = 0;
    op_t      pend_op  = OP_PLUS;
    int       sum_acc  = 0;
    int       term_acc = 0;
    bit       ovf_flag = 1'b0;
    bit       dz_flag  = 1'b0;

    result_t expected_results[$];
    int      error_count   = 0;
    int      items_sent    = 0;
    int      stall_cycles  = 0;
    int      send_idle_pct = 20;
    int      recv_idle_pct = 62;

    // Directed characters: ignored extremes, zero divisor, precedence, repeated and
    // trailing operators, product overflow
    stim_row_t directed_rows [26] = '{
        '{8'hFF,       1'b0, 1'b0, '0},
        '{"9",         1'b0, 1'b0, '0},
        '{CHAR_DIVIDE, 1'b0, 1'b0, '0},
        '{"0",         1'b1, 1'b1, '{32'sd0, 1'b0, 1'b1}},
        '{"8",         1'b0, 1'b0, '0},
        '{CHAR_MINUS,  1'b0, 1'b0, '0},
        '{"3",         1'b0, 1'b0, '0},
        '{CHAR_TIMES,  1'b0, 1'b0, '0},
        '{"5",         1'b0, 1'b0, '0},
        '{CHAR_DIVIDE, 1'b0, 1'b0, '0},
        '{"2",         1'b1, 1'b0, '0},
        '{8'h00,       1'b0, 1'b0, '0},
        '{"4",         1'b0, 1'b0, '0},
        '{CHAR_TIMES,  1'b0, 1'b0, '0},
        '{CHAR_PLUS,   1'b1, 1'b0, '0},
        '{"6",         1'b0, 1'b0, '0},
        '{"5",         1'b0, 1'b0, '0},
        '{"5",         1'b0, 1'b0, '0},
        '{"3",         1'b0, 1'b0, '0},
        '{"6",         1'b0, 1'b0, '0},
        '{CHAR_TIMES,  1'b0, 1'b0, '0},
        '{"6",         1'b0, 1'b0, '0},
        '{"5",         1'b0, 1'b0, '0},
        '{"5",         1'b0, 1'b0, '0},
        '{"3",         1'b0, 1'b0, '0},
        '{"6",         1'b1, 1'b1, '{32'sd0, 1'b1, 1'b0}}
    };

    infix_four_op_evaluator dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_char_code      (s_char_code),
        .s_is_last        (s_is_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_value          (m_value),
        .m_overflow       (m_overflow),
        .m_divide_by_zero (m_divide_by_zero)
    );

    always #4 aclk = ~aclk;

    // Wrapping 32-bit arithmetic that records any step out of signed range
    function automatic int word_add(input int a, input int b);
        longint sum;
        sum = longint'(a) + longint'(b);
        if (sum > WORD_MAX || sum < WORD_MIN) ovf_flag = 1'b1;
        return int'(sum);
    endfunction

    function automatic int word_neg(input int a);
        if (longint'(a) == WORD_MIN) ovf_flag = 1'b1;
        return -a;
    endfunction

    function automatic int word_mul(input int a, input int b);
        longint product;
        product = longint'(a) * longint'(b);
        if (product > WORD_MAX || product < WORD_MIN) ovf_flag = 1'b1;
        return int'(product);
    endfunction

    function automatic int word_div(input int a, input int b);
        if (b == 0) begin
            dz_flag = 1'b1;
            return 0;
        end
        if (longint'(a) == WORD_MIN && b == -1) begin
            ovf_flag = 1'b1;
            return a;
        end
        return a / b;
    endfunction

    // Apply the pending operator to the number read so far
    function automatic void fold_pending();
        case (pend_op)
            OP_PLUS: begin
                sum_acc  = word_add(sum_acc, term_acc);
                term_acc = num_acc;
            end
            OP_SUB: begin
                sum_acc  = word_add(sum_acc, term_acc);
                term_acc = word_neg(num_acc);
            end
            OP_TIMES:  term_acc = word_mul(term_acc, num_acc);
            default:   term_acc = word_div(term_acc, num_acc);
        endcase
        num_acc = 0;
    endfunction

    // Advance the evaluator copy by one character; emit the value on the last one
    function automatic void eval_char(input logic [CHAR_WIDTH-1:0] code, input logic last,
                                      output bit emits, output result_t outcome);
        int total;
        emits   = 1'b0;
        outcome = '0;
        if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
            num_acc = word_mul(num_acc, 10);
            num_acc = word_add(num_acc, int'(code - CHAR_ZERO));
        end else if (code == CHAR_PLUS || code == CHAR_MINUS ||
                     code == CHAR_TIMES || code == CHAR_DIVIDE) begin
            fold_pending();
            case (code)
                CHAR_PLUS:  pend_op = OP_PLUS;
                CHAR_MINUS: pend_op = OP_SUB;
                CHAR_TIMES: pend_op = OP_TIMES;
                default:    pend_op = OP_DIVIDE;
            endcase
        end
        if (last) begin
            fold_pending();
            total         = word_add(sum_acc, term_acc);
            outcome.value = dz_flag ? 0 : total;
            outcome.ov    = ovf_flag;
            outcome.dz    = dz_flag;
            emits         = 1'b1;
            num_acc       = 0;
            pend_op       = OP_PLUS;
            sum_acc       = 0;
            term_acc      = 0;
            ovf_flag      = 1'b0;
            dz_flag       = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    // Drive one character, hold it until the transfer, then record its expected value
    task automatic send_item(input logic [CHAR_WIDTH-1:0] code, input logic last,
                             input logic use_fixed, input result_t fixed_result);
        bit      emits;
        result_t outcome;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid     <= 1'b1;
        s_char_code <= code;
        s_is_last   <= last;
        do @(posedge aclk); while (!s_ready);
        eval_char(code, last, emits, outcome);
        if (emits) expected_results.push_back(use_fixed ? fixed_result : outcome);
        items_sent++;
    endtask

    // Build one expression with random content; a broken one gets stray operators
    task automatic send_expression(input bit broken);
        logic [CHAR_WIDTH-1:0] chars[$];
        int n_terms;
        int n_digits;
        n_terms = $urandom_range(1, 4);
        for (int t = 0; t < n_terms; t++) begin
            if (t > 0) begin
                if ($urandom_range(7) == 0) chars.push_back(SPACE_CHAR);
                chars.push_back(OP_CHARS[$urandom_range(3)]);
                if ($urandom_range(7) == 0) chars.push_back(SPACE_CHAR);
            end
            n_digits = ($urandom_range(15) == 0) ? $urandom_range(6, 11) : $urandom_range(1, 3);
            for (int d = 0; d < n_digits; d++)
                chars.push_back(CHAR_ZERO + 8'($urandom_range(9)));
        end
        if (broken) begin
            chars.insert($urandom_range(chars.size()), OP_CHARS[$urandom_range(3)]);
            if ($urandom_range(1) == 0) chars.push_back(OP_CHARS[$urandom_range(3)]);
        end
        if ($urandom_range(9) == 0)
            chars.insert($urandom_range(chars.size()), 8'($urandom_range(255)));
        foreach (chars[i])
            send_item(chars[i], i == chars.size() - 1, 1'b0, '0);
    endtask

    // Check each result transfer against the oldest expectation; randomize ready
    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result value %0d", m_value));
            end else begin
                want = expected_results.pop_front();
                if (m_value !== want.value)
                    report_mismatch($sformatf("value got %0d want %0d", m_value, want.value));
                if (m_overflow !== want.ov)
                    report_mismatch($sformatf("overflow got %b want %b", m_overflow, want.ov));
                if (m_divide_by_zero !== want.dz)
                    report_mismatch($sformatf("divide_by_zero got %b want %b",
                                              m_divide_by_zero, want.dz));
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // End the run when no transfer happens for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        bit      pause_done;
        int      pick;
        result_t none;
        pause_done = 1'b0;
        none       = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].code, directed_rows[i].last,
                      directed_rows[i].fixed, directed_rows[i].want);

        while (items_sent < ITEM_TARGET) begin
            // Swap the idle pattern by phase; drain fully once before the first swap
            if (items_sent >= 2 * PHASE_ITEMS) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (items_sent >= PHASE_ITEMS) begin
                if (!pause_done) begin
                    s_valid <= 1'b0;
                    do @(posedge aclk); while (expected_results.size() != 0);
                    pause_done = 1'b1;
                end
                send_idle_pct = 62;
                recv_idle_pct = 20;
            end
            pick = $urandom_range(99);
            if (pick < 85) begin
                send_expression(1'b0);
            end else if (pick < 93) begin
                send_expression(1'b1);
            end else begin
                repeat ($urandom_range(1, 3))
                    send_item(8'($urandom_range(255)), $urandom_range(3) == 0, 1'b0, none);
            end
        end

        // Drain outstanding results, then let any trailing character settle
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
